[rtl/core/dmm_lcd_frame_decoder_macros.svh]
// assertion macros for the lcd frame decoder checker
// no dependencies; included by the checker file
`ifndef DMM_LCD_FRAME_DECODER_MACROS_SVH
`define DMM_LCD_FRAME_DECODER_MACROS_SVH

// antecedent in this cycle, consequent in the next
`define DMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmm lcd check failed");

// antecedent and consequent in the same cycle
`define DMM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmm lcd check failed");

`endif

[rtl/core/dmm_lcd_pkg.sv]
// shared types, constants and segment table for the lcd frame decoder
// no dependencies
package dmm_lcd_pkg;

    localparam int FRAME_LEN = 14;

    localparam logic [3:0] HI_START = 4'h1;
    localparam logic [3:0] HI_END   = 4'he;

    localparam logic [1:0] UNIT_NONE = 2'd0;
    localparam logic [1:0] UNIT_AMP  = 2'd1;
    localparam logic [1:0] UNIT_VOLT = 2'd2;

    typedef logic [FRAME_LEN-1:0][3:0] nib_arr_t;

    // per-transfer control broadcast along the cell row
    typedef struct packed {
        logic step;
        logic restart;
    } ctl_t;

    typedef struct packed {
        logic [13:0] magnitude;
        logic        negative;
        logic [3:0]  divisor_exp;
        logic [1:0]  unit_code;
    } reading_t;

    // seven-segment pattern to digit, unknown patterns give zero
    function automatic logic [3:0] seg_digit(input logic [3:0] hi_nib, input logic [3:0] lo_nib);
        logic [6:0] code;
        code = {hi_nib[2:0], lo_nib};
        case (code)
            7'h7d:   seg_digit = 4'd0;
            7'h05:   seg_digit = 4'd1;
            7'h5b:   seg_digit = 4'd2;
            7'h1f:   seg_digit = 4'd3;
            7'h27:   seg_digit = 4'd4;
            7'h3e:   seg_digit = 4'd5;
            7'h7e:   seg_digit = 4'd6;
            7'h15:   seg_digit = 4'd7;
            7'h7f:   seg_digit = 4'd8;
            7'h3f:   seg_digit = 4'd9;
            default: seg_digit = 4'd0;
        endcase
    endfunction

endpackage

[rtl/core/dmm_lcd_frame_decoder.sv]
// top level of the multimeter lcd frame decoder
// depends on dmm_lcd_pkg, dmm_lcd_cell, dmm_lcd_decode
//
// usage
// - input channel in_valid / in_ready / rx_byte: one serial byte per transfer
// - a byte with high nibble 1 starts a frame, high nibble e ends it, others append
// - output channel out_valid / out_ready: one reading per end byte, none otherwise
// - frame_ok high when the frame held exactly 14 bytes and was decoded; when low,
//   magnitude, negative, divisor_exp and unit_code repeat the last good reading
// - the reading is shown in the cycle after the end byte transfer
// - one byte per cycle while in_ready is high; the frame is stored in a row of 14 cells,
//   each holding one nibble and handing its fill bit to the next, and the
//   segment decode runs in the same cycle as the end byte
// - the output register frees in the cycle it is taken, so bytes keep flowing
//   while out_ready stays high; in_ready drops only while a reading waits
// - at reset the byte count is zero, the held reading is zero with unit unknown,
//   and no reading is pending; frame contents are not cleared
// - when the receiver stalls, the pending reading holds and input stalls too
module dmm_lcd_frame_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [13:0] magnitude,
    output logic        negative,
    output logic [3:0]  divisor_exp,
    output logic [1:0]  unit_code,
    output logic        frame_ok
);
    import dmm_lcd_pkg::*;

    logic                 in_xfer;
    logic                 is_start;
    logic                 is_end;
    ctl_t                 ctl;
    logic [FRAME_LEN:0]   chain;       // fill bits along the row, chain[0] tied high
    nib_arr_t             nibs;
    reading_t             decoded;
    logic                 good_frame;

    logic                 over_reg;    // count has reached 15
    logic                 over_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 frame_ok_reg;
    logic                 frame_ok_next;
    reading_t             held_reg;    // shown reading, doubles as the held reading
    reading_t             held_next;

    assign in_ready = ~out_valid_reg | out_ready;
    assign in_xfer  = in_valid & in_ready;
    assign is_start = (rx_byte[7:4] == HI_START);
    assign is_end   = (rx_byte[7:4] == HI_END);

    assign ctl.restart = in_xfer & is_start;
    assign ctl.step    = in_xfer & ~is_start;

    assign chain[0] = 1'b1;

    // frame store: one cell per byte position
    for (genvar i = 0; i < FRAME_LEN; i++)
    begin : g_cell
        dmm_lcd_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .head     (i == 0),
            .pass_in  (chain[i]),
            .nib_in   (rx_byte[3:0]),
            .pass_out (chain[i+1]),
            .nib_out  (nibs[i])
        );
    end

    dmm_lcd_decode u_decode
    (
        .nibs    (nibs),
        .reading (decoded)
    );

    // count was 13 before this end byte, so it lands on 14
    assign good_frame = chain[FRAME_LEN-1] & ~chain[FRAME_LEN];

    always_comb
    begin
        over_next      = over_reg;
        out_valid_next = out_valid_reg;
        frame_ok_next  = frame_ok_reg;
        held_next      = held_reg;

        // saturating top of the count
        if (ctl.restart)
        begin
            over_next = 1'b0;
        end
        else if (ctl.step)
        begin
            over_next = over_reg | chain[FRAME_LEN];
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (ctl.step && is_end)
        begin
            out_valid_next = 1'b1;
            frame_ok_next  = good_frame;
            if (good_frame)
            begin
                held_next = decoded;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            over_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            frame_ok_reg  <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            over_reg      <= over_next;
            out_valid_reg <= out_valid_next;
            frame_ok_reg  <= frame_ok_next;
            held_reg      <= held_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign magnitude   = held_reg.magnitude;
    assign negative    = held_reg.negative;
    assign divisor_exp = held_reg.divisor_exp;
    assign unit_code   = held_reg.unit_code;
    assign frame_ok    = frame_ok_reg;

endmodule

[rtl/core/dmm_lcd_cell.sv]
// one frame position: stored nibble plus a fill bit handed down the row
// depends on dmm_lcd_pkg
module dmm_lcd_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  dmm_lcd_pkg::ctl_t ctl,
    input  logic              head,
    input  logic              pass_in,
    input  logic [3:0]        nib_in,
    output logic              pass_out,
    output logic [3:0]        nib_out
);
    import dmm_lcd_pkg::*;

    logic       pass_reg;
    logic       pass_next;
    logic [3:0] nib_reg;
    logic       wr_en;

    // this cell is the write slot when the left side is filled and this one is not
    always_comb
    begin
        wr_en     = 1'b0;
        pass_next = pass_reg;
        if (ctl.restart)
        begin
            wr_en     = head;
            pass_next = head;
        end
        else if (ctl.step)
        begin
            wr_en     = pass_in & ~pass_reg;
            pass_next = pass_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg <= 1'b0;
        end
        else
        begin
            pass_reg <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            nib_reg <= nib_in;
        end
    end

    assign pass_out = pass_reg;
    assign nib_out  = nib_reg;

endmodule

[rtl/core/dmm_lcd_decode.sv]
// segment decode of a full frame into magnitude, sign, exponent and unit
// depends on dmm_lcd_pkg
module dmm_lcd_decode
(
    input  dmm_lcd_pkg::nib_arr_t nibs,
    output dmm_lcd_pkg::reading_t reading
);
    import dmm_lcd_pkg::*;

    logic [3:0]  d3;
    logic [3:0]  d2;
    logic [3:0]  d1;
    logic [3:0]  d0;
    logic [13:0] mag;
    logic [3:0]  ex;

    always_comb
    begin
        d3 = seg_digit(nibs[1], nibs[2]);
        d2 = seg_digit(nibs[3], nibs[4]);
        d1 = seg_digit(nibs[5], nibs[6]);
        d0 = seg_digit(nibs[7], nibs[8]);

        // constant weights, small shift-add logic
        mag = 14'(d3) * 14'd1000 + 14'(d2) * 14'd100 + 14'(d1) * 14'd10 + 14'(d0);

        // decimal points, then milli and micro
        ex = (nibs[3][3]  ? 4'd3 : 4'd0)
           + (nibs[5][3]  ? 4'd2 : 4'd0)
           + (nibs[7][3]  ? 4'd1 : 4'd0)
           + (nibs[10][3] ? 4'd3 : 4'd0)
           + (nibs[9][3]  ? 4'd3 : 4'd0);

        reading.magnitude   = mag;
        reading.negative    = nibs[1][3];
        reading.divisor_exp = ex;
        if (nibs[12][3])
        begin
            reading.unit_code = UNIT_AMP;
        end
        else if (nibs[12][2])
        begin
            reading.unit_code = UNIT_VOLT;
        end
        else
        begin
            reading.unit_code = UNIT_NONE;
        end
    end

endmodule

[rtl/core/dmm_lcd_checker.sv]
// port-level checks for the lcd frame decoder, bound to the top level
// depends on dmm_lcd_pkg and dmm_lcd_frame_decoder_macros.svh
`include "dmm_lcd_frame_decoder_macros.svh"

module dmm_lcd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  rx_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [13:0] magnitude,
    input logic        negative,
    input logic [3:0]  divisor_exp,
    input logic [1:0]  unit_code,
    input logic        frame_ok
);
    import dmm_lcd_pkg::*;

    // stalled reading holds
    `DMM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(magnitude) && $stable(negative) && $stable(divisor_exp) && $stable(unit_code) && $stable(frame_ok))

    // every end byte transfer gives a reading next cycle
    `DMM_ASSERT_NEXT(a_end_gives_out, clk, rst_n, in_valid && in_ready && rx_byte[7:4] == HI_END, out_valid)

    // other bytes give no reading
    `DMM_ASSERT_NEXT(a_no_spurious, clk, rst_n, in_valid && in_ready && rx_byte[7:4] != HI_END && !(out_valid && !out_ready), !out_valid)

    // decoded values stay in range
    `DMM_ASSERT_SAME(a_range, clk, rst_n, out_valid, magnitude <= 14'd9999 && divisor_exp <= 4'd12 && (unit_code == UNIT_NONE || unit_code == UNIT_AMP || unit_code == UNIT_VOLT))

endmodule

bind dmm_lcd_frame_decoder dmm_lcd_checker u_dmm_lcd_checker (.*);

[sim/tb_top.sv]
// self-checking bench for the multimeter lcd frame decoder
// needs dmm_lcd_pkg and dmm_lcd_frame_decoder with its cell and decode modules
`timescale 1ns / 100ps

module tb_top;

    import dmm_lcd_pkg::*;

    // one planned byte, optionally held back until every reading has arrived
    typedef struct packed {
        logic [7:0] value;
        logic       drain_first;
    } serial_item_t;

    // one predicted reading as it should leave the block
    typedef struct packed {
        reading_t rd;
        logic     ok;
    } lcd_result_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_MOSTLY,
        SINK_SPARSE,
        SINK_BLOCKS
    } sink_mode_e;

    localparam int         RANDOM_ITEMS = 800;
    localparam int         IDLE_LIMIT   = 2000;
    localparam logic [3:0] COUNT_CAP    = 4'd15;

    // segment codes {hi[2:0], lo[3:0]} of digits 9 down to 0
    localparam logic [9:0][6:0] SEG_CODE = {
        7'h3f, 7'h7f, 7'h15, 7'h7e, 7'h3e, 7'h27, 7'h1f, 7'h5b, 7'h05, 7'h7d
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [13:0] magnitude;
    logic        negative;
    logic [3:0]  divisor_exp;
    logic [1:0]  unit_code;
    logic        frame_ok;

    // stimulus and expectation stores
    serial_item_t byte_plan[$];
    lcd_result_t  readings_due[$];
    int unsigned  results_due  = 0;
    int unsigned  results_seen = 0;
    int unsigned  err_count    = 0;

    // predictor state
    logic [3:0] frame_nib [FRAME_LEN];
    logic [3:0] frame_count = 4'd0;
    reading_t   held = '0;

    // driver pacing
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    // receiver pacing
    sink_mode_e  sink_mode  = SINK_OPEN;
    int unsigned phase_left = 0;
    int unsigned stall_len  = 1;
    int unsigned stall_cnt  = 0;

    int unsigned idle_cycles = 0;

    dmm_lcd_frame_decoder i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .magnitude   (magnitude),
        .negative    (negative),
        .divisor_exp (divisor_exp),
        .unit_code   (unit_code),
        .frame_ok    (frame_ok)
    );

    always #2 clk = ~clk;

    // segment pattern lookup, unknown codes read as zero
    function automatic int unsigned lcd_digit_of(input logic [6:0] code);
        lcd_digit_of = 0;
        for (int d = 0; d < 10; d++)
        begin
            if (SEG_CODE[d] == code)
                lcd_digit_of = d;
        end
    endfunction

    // advance the predicted frame by one byte, queue a reading on an end byte
    task automatic lcd_absorb_byte(input logic [7:0] b, output bit produced);
        lcd_result_t res;
        int unsigned mag;
        logic [3:0]  ex;
        produced = 1'b0;
        // a start byte restarts the count, then stores like any other byte
        if (b[7:4] == HI_START)
            frame_count = 4'd0;
        if (frame_count < FRAME_LEN)
            frame_nib[frame_count] = b[3:0];
        if (frame_count != COUNT_CAP)
            frame_count = frame_count + 4'd1;
        if (b[7:4] == HI_END)
        begin
            res.ok = (frame_count == FRAME_LEN);
            if (res.ok)
            begin
                mag = 0;
                for (int k = 0; k < 4; k++)
                    mag = mag * 10 + lcd_digit_of({frame_nib[2*k+1][2:0], frame_nib[2*k+2]});
                held.magnitude = mag[13:0];
                held.negative  = frame_nib[1][3];
                // decimal points weigh 3, 2, 1; milli and micro add 3 each
                ex = 4'd0;
                if (frame_nib[3][3])  ex = ex + 4'd3;
                if (frame_nib[5][3])  ex = ex + 4'd2;
                if (frame_nib[7][3])  ex = ex + 4'd1;
                if (frame_nib[10][3]) ex = ex + 4'd3;
                if (frame_nib[9][3])  ex = ex + 4'd3;
                held.divisor_exp = ex;
                // amperes wins when both unit bits are lit
                if (frame_nib[12][3])
                    held.unit_code = UNIT_AMP;
                else if (frame_nib[12][2])
                    held.unit_code = UNIT_VOLT;
                else
                    held.unit_code = UNIT_NONE;
            end
            res.rd = held;
            readings_due.push_back(res);
            produced = 1'b1;
        end
    endtask

    task automatic plan_byte(input logic [7:0] v, input bit hold);
        serial_item_t it;
        it.value       = v;
        it.drain_first = hold;
        byte_plan.push_back(it);
    endtask

    // high nibble of a middle byte: usually its position tag, never start or end
    function automatic logic [3:0] mid_hi(input int pos);
        logic [3:0] h;
        h = 4'(pos + 1);
        if (pos > 12 || $urandom_range(9) == 0)
        begin
            do
                h = 4'($urandom_range(15));
            while (h == HI_START || h == HI_END);
        end
        return h;
    endfunction

    // mostly real digit patterns, sometimes garbage segments
    function automatic logic [6:0] pick_digit_code();
        if ($urandom_range(9) == 0)
            return 7'($urandom_range(127));
        return SEG_CODE[$urandom_range(9)];
    endfunction

    // start byte, n_mid middle bytes, end byte; n_mid of 12 gives a full frame
    task automatic plan_frame(input int n_mid, input bit hold);
        logic [6:0] code;
        logic [3:0] nib;
        code = 7'd0;
        plan_byte({HI_START, 4'($urandom_range(15))}, hold);
        for (int p = 1; p <= n_mid; p++)
        begin
            if (p <= 8 && p[0])
            begin
                code = pick_digit_code();
                nib  = {1'($urandom_range(1)), code[6:4]};
            end
            else if (p <= 8)
                nib = code[3:0];
            else
                nib = 4'($urandom_range(15));
            plan_byte({mid_hi(p), nib}, 1'b0);
        end
        plan_byte({HI_END, 4'($urandom_range(15))}, 1'b0);
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endfunction

    // driver: presents planned bytes in bursts, predicts on each accepted transfer
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        serial_item_t nxt;
        bit           produced;
        int unsigned  due_now;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'h00;
        end
        else
        begin
            produced = 1'b0;
            if (in_valid && in_ready)
                lcd_absorb_byte(rx_byte, produced);
            // count the reading caused at this very edge
            due_now = results_due + produced;
            if (produced)
                results_due <= due_now;

            if (in_valid && !in_ready)
            begin
                // transfer still pending, hold valid and payload
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (byte_plan.size() != 0 &&
                     !(byte_plan[0].drain_first && due_now != results_seen))
            begin
                nxt = byte_plan.pop_front();
                in_valid <= 1'b1;
                rx_byte  <= nxt.value;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(48, 1);
                    gap_left   = ($urandom_range(5) == 0) ? 0 : $urandom_range(12, 1);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: ready pattern changes mode whenever its phase runs out
    always @(posedge clk or negedge rst_n)
    begin : sink_proc
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (phase_left == 0)
            begin
                sink_mode  = sink_mode_e'($urandom_range(3));
                phase_left = $urandom_range(160, 16);
                stall_len  = $urandom_range(40, 1);
                stall_cnt  = 0;
            end
            else
                phase_left--;
            case (sink_mode)
                SINK_OPEN:   out_ready <= 1'b1;
                SINK_MOSTLY: out_ready <= ($urandom_range(3) != 0);
                SINK_SPARSE: out_ready <= ($urandom_range(3) == 0);
                default:
                begin
                    // long stall, then a single ready cycle
                    if (stall_cnt >= stall_len)
                    begin
                        out_ready <= 1'b1;
                        stall_cnt = 0;
                    end
                    else
                    begin
                        out_ready <= 1'b0;
                        stall_cnt++;
                    end
                end
            endcase
        end
    end

    // monitor: each accepted reading against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        lcd_result_t want;
        if (!rst_n)
            results_seen <= 0;
        else if (out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (readings_due.size() == 0)
            begin
                $error("reading transfer with none expected");
                err_count++;
            end
            else
            begin
                want = readings_due.pop_front();
                check_field("magnitude", 16'(want.rd.magnitude), 16'(magnitude));
                check_field("negative", 16'(want.rd.negative), 16'(negative));
                check_field("divisor_exp", 16'(want.rd.divisor_exp), 16'(divisor_exp));
                check_field("unit_code", 16'(want.rd.unit_code), 16'(unit_code));
                check_field("frame_ok", 16'(want.ok), 16'(frame_ok));
            end
        end
    end

    // watchdog: too long without any transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int  pick;
        bit  hold;
        int  n_directed;

        // bytes before any start, then an end: short frame repeats the zero reading
        plan_byte(8'h00, 1'b0);
        plan_byte(8'hef, 1'b0);
        // full frame: digits 8, 9, unknown, 0; minus, every point, milli, micro,
        // both unit bits lit
        plan_byte(8'h1f, 1'b0);
        plan_byte(8'h2f, 1'b0);
        plan_byte(8'h3f, 1'b0);
        plan_byte(8'h4b, 1'b0);
        plan_byte(8'h5f, 1'b0);
        plan_byte(8'h68, 1'b0);
        plan_byte(8'h70, 1'b0);
        plan_byte(8'h8f, 1'b0);
        plan_byte(8'h9d, 1'b0);
        plan_byte(8'ha8, 1'b0);
        plan_byte(8'hb8, 1'b0);
        plan_byte(8'hc0, 1'b0);
        plan_byte(8'hdc, 1'b0);
        plan_byte(8'he0, 1'b0);
        // bytes after the end keep appending and saturate the count
        plan_byte(8'hff, 1'b0);
        plan_byte(8'he5, 1'b0);
        // start directly followed by end
        plan_byte(8'h10, 1'b0);
        plan_byte(8'he0, 1'b0);
        n_directed = byte_plan.size();

        while (byte_plan.size() < n_directed + RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            hold = (byte_plan.size() == n_directed) || ($urandom_range(29) == 0);
            if (pick < 70)
                plan_frame(12, hold);
            else if (pick < 80)
                plan_frame($urandom_range(11), hold);
            else if (pick < 88)
                plan_frame($urandom_range(20, 13), hold);
            else if (pick < 94)
            begin
                // raw noise, any byte value
                plan_byte(8'($urandom_range(255)), hold);
                repeat ($urandom_range(5))
                    plan_byte(8'($urandom_range(255)), 1'b0);
            end
            else
            begin
                // frame cut off by a fresh start
                plan_byte({HI_START, 4'($urandom_range(15))}, hold);
                for (int p = 1; p <= $urandom_range(8, 1); p++)
                    plan_byte({mid_hi(p), 4'($urandom_range(15))}, 1'b0);
                plan_frame(12, 1'b0);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // all bytes taken and every predicted reading arrived
        do
            @(negedge clk);
        while (byte_plan.size() != 0 || in_valid || results_due != results_seen);
        repeat (8) @(negedge clk);

        if (readings_due.size() != 0)
        begin
            $error("%0d expected readings never arrived", readings_due.size());
            err_count++;
        end
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
